### rtl/core/kai_pkg.sv
// Keyframe angle interpolator: shared types and constants.
// No dependencies; used by keyframe_angle_interpolator_core.
package kai_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned ANGLE_W = 16;

  // Store geometry and timer width (fixed by the field layout)
  localparam int unsigned MAX_KEYS  = 8;
  localparam int unsigned NUM_LIMBS = 4;
  localparam int unsigned TIME_BITS = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_DURATION = 3'd0,
    REG_LOOP_ENABLE   = 3'd1,
    REG_PLAY_SPEED    = 3'd2,
    REG_KEY_COUNT0    = 3'd3,
    REG_KEY_COUNT1    = 3'd4,
    REG_KEY_COUNT2    = 3'd5,
    REG_KEY_COUNT3    = 3'd6
  } cfg_reg_t;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_MULT   = 11'b00000000010,
    ST_WRAP   = 11'b00000000100,
    ST_LIMB   = 11'b00000001000,
    ST_RD     = 11'b00000010000,
    ST_CMP    = 11'b00000100000,
    ST_PROD   = 11'b00001000000,
    ST_DIV    = 11'b00010000000,
    ST_FIX    = 11'b00100000000,
    ST_NEXT   = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

endpackage

### rtl/core/keyframe_angle_interpolator_core.sv
// Keyframe angle interpolator, top level and only module.
// Depends on kai_pkg (register codes, request kinds, state encoding, store geometry).
//
// Channel | Dir | tdata fields, LSB first                       | tuser
// in_     | in  | frame_delta[15:0] limb_select[17:16]          | req_type
//         |     | key_slot[20:18] key_time[40:21] angle[56:41]  |
// out_    | out | angle_limb0..3 [63:0], timer_now [83:64]      | -
// cfg_    | in  | plain write: cfg_we, cfg_idx, cfg_wdata       | -
//
// A write request is accepted, then written to the key memory. A tick runs the timer
// update with its modulo, then per limb a serial key search, one
// key read per step from the key memory, and for a bracketing pair a restoring
// divide of TIME_BITS+17 steps.
// Key memories hold no reset contents. Reset is synchronous, active low; the result
// register waits for out_tready while no new request is taken.
module keyframe_angle_interpolator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // frame_delta, limb_select, key_slot, key_time, key_angle
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // angle_limb0..3, timer_now
  input  logic                            cfg_we,
  input  logic [kai_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kai_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned MAX_KEYS  = kai_pkg::MAX_KEYS;
  localparam int unsigned NUM_LIMBS = kai_pkg::NUM_LIMBS;
  localparam int unsigned TIME_BITS = kai_pkg::TIME_BITS;
  localparam int unsigned SLOT_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned LIMB_W  = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;
  localparam int unsigned ADDR_W  = SLOT_W + LIMB_W;
  localparam int unsigned DEPTH   = NUM_LIMBS * MAX_KEYS;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SUM_W   = 29;        // timer + (16b*12b>>8)
  localparam int unsigned QW      = TIME_BITS + 17; // |dt*dA| width
  localparam int unsigned DCNT_W  = $clog2(QW + 1);
  localparam int unsigned MCNT_W  = $clog2(SUM_W + 1);
  localparam int unsigned AW      = kai_pkg::ANGLE_W;

  // Configuration
  logic [19:0] clip_duration_r;
  logic        loop_enable_r;
  logic [11:0] play_speed_r;
  logic [CNT_W-1:0] key_count_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_duration_r <= 20'd4096;
      loop_enable_r   <= 1'b0;
      play_speed_r    <= 12'd256;
      for (int i = 0; i < 4; i++) key_count_r[i] <= '0;
    end else if (cfg_we) begin
      case (kai_pkg::cfg_reg_t'(cfg_idx))
        kai_pkg::REG_CLIP_DURATION: clip_duration_r <= cfg_wdata;
        kai_pkg::REG_LOOP_ENABLE:   loop_enable_r <= cfg_wdata[0];
        kai_pkg::REG_PLAY_SPEED:    play_speed_r <= cfg_wdata[11:0];
        kai_pkg::REG_KEY_COUNT0:    key_count_r[0] <= cfg_wdata[3:0];
        kai_pkg::REG_KEY_COUNT1:    key_count_r[1] <= cfg_wdata[3:0];
        kai_pkg::REG_KEY_COUNT2:    key_count_r[2] <= cfg_wdata[3:0];
        kai_pkg::REG_KEY_COUNT3:    key_count_r[3] <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Input fields
  wire [15:0] f_delta = in_tdata[15:0];
  wire [1:0]  f_limb  = in_tdata[17:16];
  wire [2:0]  f_slot  = in_tdata[20:18];
  wire [19:0] f_time  = in_tdata[40:21];
  wire [15:0] f_angle = in_tdata[56:41];

  kai_pkg::state_t state_r;

  // Key memories: one write port, one registered read port
  logic [TIME_BITS-1:0] time_mem [DEPTH];
  logic [AW-1:0]        ang_mem  [DEPTH];
  logic                 mem_we_r;
  logic [ADDR_W-1:0]    mem_waddr_r;
  logic [TIME_BITS-1:0] mem_wtime_r;
  logic [AW-1:0]        mem_wang_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] rd_time_r;
  logic [AW-1:0]        rd_ang_r;

  always_ff @(posedge clk) begin
    if (mem_we_r) begin
      time_mem[mem_waddr_r] <= mem_wtime_r;
      ang_mem[mem_waddr_r]  <= mem_wang_r;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_ang_r  <= ang_mem[rd_addr];
  end

  // Datapath registers
  logic [TIME_BITS-1:0] timer_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     rem_r;
  logic [MCNT_W-1:0]    mcnt_r;
  logic [LIMB_W-1:0]    limb_r;
  logic [SLOT_W:0]      key_r;       // index of the key being read (key b once phase_r is set)
  logic                 phase_r;     // 0: waiting key a, 1: key b
  logic [TIME_BITS-1:0] ta_r, tb_r;
  logic signed [AW-1:0] aa_r, ab_r;
  logic [QW-1:0]        num_r;
  logic                 neg_r;
  logic [QW-1:0]        quo_r;
  logic [QW:0]          drem_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic signed [AW-1:0] ang_r [4];
  logic                 out_valid_r;

  logic [CNT_W-1:0] cnt_eff;
  always_comb begin
    cnt_eff = key_count_r[limb_r];
    if (32'(cnt_eff) > MAX_KEYS) cnt_eff = CNT_W'(MAX_KEYS);
  end

  always_comb begin
    rd_addr = {limb_r, key_r[SLOT_W-1:0]};
  end

  wire [SUM_W-1:0] dur_ext = SUM_W'(clip_duration_r);
  wire [SUM_W-1:0] dur_sh  = dur_ext << mcnt_r;
  wire [TIME_BITS:0] dt  = {1'b0, timer_r} - {1'b0, ta_r};
  wire [TIME_BITS-1:0] den = tb_r - ta_r;
  wire signed [AW:0] da = {ab_r[AW-1], ab_r} - {aa_r[AW-1], aa_r};
  wire [AW:0] da_mag = da[AW] ? (~da + 1'b1) : da;
  wire [QW:0] drem_sh = {drem_r[QW-1:0], num_r[QW-1]};

  assign in_tready  = (state_r == kai_pkg::ST_IDLE) && !out_valid_r && !mem_we_r;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kai_pkg::ST_IDLE;
      timer_r     <= '0;
      mem_we_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mem_we_r <= 1'b0;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        kai_pkg::ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            if (in_tuser == kai_pkg::REQ_WRITE) begin
              if (32'(f_limb) < NUM_LIMBS && 32'(f_slot) < MAX_KEYS) begin
                mem_we_r    <= 1'b1;
                mem_waddr_r <= {LIMB_W'(f_limb), SLOT_W'(f_slot)};
                mem_wtime_r <= TIME_BITS'(f_time);
                mem_wang_r  <= f_angle;
              end
            end else begin
              sum_r   <= SUM_W'((28'(f_delta) * 28'(play_speed_r)) >> 8);
              state_r <= kai_pkg::ST_MULT;
            end
          end
        end
        kai_pkg::ST_MULT: begin
          sum_r  <= sum_r + SUM_W'(timer_r);
          // sum stays below 2^(TIME_BITS+1): quotient bits TIME_BITS..0
          mcnt_r <= MCNT_W'(TIME_BITS);
          state_r <= kai_pkg::ST_WRAP;
        end
        kai_pkg::ST_WRAP: begin
          // looping: restoring modulo, one shift of the duration per cycle; zero for zero duration; else clamp
          if (!loop_enable_r) begin
            timer_r <= TIME_BITS'((sum_r > dur_ext) ? dur_ext : sum_r);
            limb_r <= '0;
            state_r <= kai_pkg::ST_LIMB;
          end else if (clip_duration_r == '0) begin
            timer_r <= '0;
            limb_r <= '0;
            state_r <= kai_pkg::ST_LIMB;
          end else begin
            if (sum_r >= dur_sh && (dur_sh >> mcnt_r) == dur_ext) sum_r <= sum_r - dur_sh;
            if (mcnt_r == '0) begin
              mcnt_r <= mcnt_r;
              if (sum_r < dur_ext) begin
                timer_r <= TIME_BITS'(sum_r);
                limb_r <= '0;
                state_r <= kai_pkg::ST_LIMB;
              end
            end else begin
              mcnt_r <= mcnt_r - 1'b1;
            end
          end
        end
        kai_pkg::ST_LIMB: begin
          key_r   <= '0;
          phase_r <= 1'b0;
          if (cnt_eff == '0) begin
            ang_r[2'(limb_r)] <= '0;
            state_r <= kai_pkg::ST_NEXT;
          end else begin
            state_r <= kai_pkg::ST_RD;
          end
        end
        kai_pkg::ST_RD: begin
          // read of key_r issued this cycle, data next
          state_r <= kai_pkg::ST_CMP;
        end
        kai_pkg::ST_CMP: begin
          if (!phase_r) begin
            ta_r <= rd_time_r;
            aa_r <= rd_ang_r;
            if (cnt_eff == CNT_W'(1)) begin
              ang_r[2'(limb_r)] <= rd_ang_r;
              state_r <= kai_pkg::ST_NEXT;
            end else begin
              phase_r <= 1'b1;
              key_r <= key_r + 1'b1;
              state_r <= kai_pkg::ST_RD;
            end
          end else begin
            tb_r <= rd_time_r;
            ab_r <= rd_ang_r;
            if (timer_r >= ta_r && timer_r <= rd_time_r) begin
              state_r <= kai_pkg::ST_PROD;
            end else if (CNT_W'(key_r) + 1'b1 >= cnt_eff) begin
              ang_r[2'(limb_r)] <= rd_ang_r;
              state_r <= kai_pkg::ST_NEXT;
            end else begin
              ta_r <= rd_time_r;
              aa_r <= rd_ang_r;
              key_r <= key_r + 1'b1;
              state_r <= kai_pkg::ST_RD;
            end
          end
        end
        kai_pkg::ST_PROD: begin
          if (den == '0) begin
            ang_r[2'(limb_r)] <= aa_r;
            state_r <= kai_pkg::ST_NEXT;
          end else begin
            num_r  <= QW'(dt[TIME_BITS-1:0] * da_mag);
            neg_r  <= da[AW];
            quo_r  <= '0;
            drem_r <= '0;
            dcnt_r <= DCNT_W'(QW);
            state_r <= kai_pkg::ST_DIV;
          end
        end
        kai_pkg::ST_DIV: begin
          num_r <= num_r << 1;
          if (drem_sh >= (QW+1)'(den)) begin
            drem_r <= drem_sh - (QW+1)'(den);
            quo_r  <= {quo_r[QW-2:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            quo_r  <= {quo_r[QW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == DCNT_W'(1)) state_r <= kai_pkg::ST_FIX;
        end
        kai_pkg::ST_FIX: begin
          // floor division: negative with remainder rounds one further down
          if (neg_r)
            ang_r[2'(limb_r)] <= aa_r - AW'(quo_r) - AW'(drem_r != '0);
          else
            ang_r[2'(limb_r)] <= aa_r + AW'(quo_r);
          state_r <= kai_pkg::ST_NEXT;
        end
        kai_pkg::ST_NEXT: begin
          if (32'(limb_r) + 1 >= NUM_LIMBS || limb_r == LIMB_W'(3)) begin
            state_r <= kai_pkg::ST_OUT;
          end else begin
            limb_r <= limb_r + 1'b1;
            state_r <= kai_pkg::ST_LIMB;
          end
        end
        kai_pkg::ST_OUT: begin
          for (int l = 0; l < 4; l++)
            if (l >= NUM_LIMBS) ang_r[l] <= '0;
          out_valid_r <= 1'b1;
          state_r <= kai_pkg::ST_IDLE;
        end
        default: state_r <= kai_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_tdata = {4'd0, 20'(timer_r), ang_r[3], ang_r[2], ang_r[1], ang_r[0]};

endmodule

### tb/tb.sv
// Self-checking testbench for keyframe_angle_interpolator_core.
// Holds a pose predictor (timer advance, key search, interpolation) in a small class;
// needs kai_pkg and the core RTL only.
module tb;

  // Predicts the pose (four limb angles plus timer) returned for each tick request.
  class pose_scoreboard;
    logic [19:0]        clip_dur;
    logic               wrap_on;
    logic [11:0]        speed;
    logic [3:0]         key_cnt[4];
    logic [19:0]        timer;
    logic [19:0]        key_t[32];
    logic signed [15:0] key_a[32];
    logic [87:0]        pose_queue[$];
    int                 mismatches;

    function new();
      clip_dur = 20'd4096;
      wrap_on = 1'b0;
      speed = 12'd256;
      foreach (key_cnt[i]) key_cnt[i] = 4'd0;
      timer = 20'd0;
      mismatches = 0;
    endfunction

    function void set_reg(kai_pkg::cfg_reg_t r, logic [19:0] v);
      case (r)
        kai_pkg::REG_CLIP_DURATION: clip_dur = v;
        kai_pkg::REG_LOOP_ENABLE:   wrap_on = v[0];
        kai_pkg::REG_PLAY_SPEED:    speed = v[11:0];
        kai_pkg::REG_KEY_COUNT0:    key_cnt[0] = v[3:0];
        kai_pkg::REG_KEY_COUNT1:    key_cnt[1] = v[3:0];
        kai_pkg::REG_KEY_COUNT2:    key_cnt[2] = v[3:0];
        kai_pkg::REG_KEY_COUNT3:    key_cnt[3] = v[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pose_queue.size();
    endfunction

    // First slot-order pair bracketing the timer; floor rounding of the interpolated offset.
    function logic signed [15:0] limb_angle(int l);
      int cnt;
      int base;
      longint ta, tb, aa, ab, den, num, q, t;
      cnt = (key_cnt[l] > 8) ? 8 : key_cnt[l];
      base = l * 8;
      t = timer;
      if (cnt == 0) return 16'sd0;
      if (cnt == 1) return key_a[base];
      for (int i = 0; i + 1 < cnt; i++) begin
        ta = key_t[base+i];
        tb = key_t[base+i+1];
        aa = key_a[base+i];
        ab = key_a[base+i+1];
        if (t >= ta && t <= tb) begin
          den = tb - ta;
          if (den == 0) return aa[15:0];
          num = (t - ta) * (ab - aa);
          q = (num >= 0) ? num / den : -((-num + den - 1) / den);
          return 16'(aa + q);
        end
      end
      return key_a[base+cnt-1];
    endfunction

    function void note_request(logic req, logic [63:0] d);
      longint sum;
      logic [87:0] pose;
      if (req == kai_pkg::REQ_WRITE) begin
        key_t[d[17:16]*8 + d[20:18]] = d[40:21];
        key_a[d[17:16]*8 + d[20:18]] = d[56:41];
        return;
      end
      sum = longint'(timer) + ((longint'(d[15:0]) * longint'(speed)) >> 8);
      if (wrap_on) sum = (clip_dur == 0) ? 0 : sum % clip_dur;
      else if (sum > clip_dur) sum = clip_dur;
      timer = sum[19:0];
      pose = '0;
      for (int l = 0; l < 4; l++) pose[l*16 +: 16] = limb_angle(l);
      pose[83:64] = timer;
      pose_queue.push_back(pose);
    endfunction

    function void check_pose(logic [87:0] got);
      logic [87:0] exp_pose;
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_pose = pose_queue.pop_front();
      for (int l = 0; l < 4; l++)
        if (got[l*16 +: 16] !== exp_pose[l*16 +: 16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle_limb%0d: expected %0d got %0d", l,
                     $signed(exp_pose[l*16 +: 16]), $signed(got[l*16 +: 16]));
        end
      if (got[83:64] !== exp_pose[83:64]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("timer_now: expected %0d got %0d", exp_pose[83:64], got[83:64]);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [63:0]                    in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [87:0]                    out_tdata;
  logic                           cfg_we;
  logic [kai_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [kai_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pose_scoreboard sb;
  bit send_calm;     // sender runs back to back
  bit recv_calm;     // receiver never stalls
  logic [19:0] cur_dur;

  keyframe_angle_interpolator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // One request: optional gap, then hold valid until the handshake.
  // Valid is left high after acceptance so back-to-back requests never toggle it.
  task automatic send_req(logic req, logic [15:0] delta, logic [1:0] limb, logic [2:0] slot,
                          logic [19:0] ktime, logic [15:0] kangle);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, kangle, ktime, slot, limb, delta};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, {7'd0, kangle, ktime, slot, limb, delta});
  endtask

  task automatic tick(logic [15:0] delta);
    send_req(kai_pkg::REQ_TICK, delta, 2'($urandom), 3'($urandom), 20'($urandom),
             16'($urandom));
  endtask

  task automatic put_key(logic [1:0] limb, logic [2:0] slot, logic [19:0] t, logic [15:0] a);
    send_req(kai_pkg::REQ_WRITE, 16'($urandom), limb, slot, t, a);
  endtask

  // Drop valid, drain every expected pose, then let a trailing key write settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(kai_pkg::cfg_reg_t r, logic [19:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    sb.set_reg(r, v);
    if (r == kai_pkg::REG_CLIP_DURATION) cur_dur = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Rewrite all eight slots of a limb. Mode 0: ascending times inside the clip,
  // mode 1: ascending with repeated times, otherwise unsorted random times inside the clip.
  task automatic load_track(logic [1:0] limb, int mode);
    logic [19:0] times[$];
    logic [19:0] span;
    span = (cur_dur == 0) ? 20'hFFFFF : cur_dur;
    times = {};
    for (int i = 0; i < 8; i++) times.push_back(20'($urandom_range(0, span)));
    if (mode <= 1) times.sort();
    if (mode == 1)
      for (int i = 1; i < 8; i++) if ($urandom_range(0, 2) == 0) times[i] = times[i-1];
    for (int i = 0; i < 8; i++) put_key(limb, 3'(i), times[i], 16'($urandom));
  endtask

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(0, 4095));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [19:0] pick_dur();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'd1;
      2: return 20'hFFFFF;
      3: return 20'($urandom);
      default: return 20'($urandom_range(256, 20'h20000));
    endcase
  endfunction

  function automatic logic [19:0] pick_count();
    case ($urandom_range(0, 4))
      0: return 20'd0;
      1: return 20'd1;
      2: return 20'd8;
      default: return 20'($urandom_range(2, 8));
    endcase
  endfunction

  // Receiver: random stalls per result, none while recv_calm is set.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = recv_calm ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_pose(out_tdata);
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = kai_pkg::REQ_TICK;
    cfg_we = 1'b0;
    cfg_idx = kai_pkg::REG_CLIP_DURATION;
    cfg_wdata = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    cur_dur = 20'd4096;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, empty tracks, extreme deltas.
    tick(16'h0000);
    tick(16'd1000);
    tick(16'hFFFF);                // clamps at the clip length
    // Fill every slot so no key is ever read unwritten. Limb 0 spans the angle
    // extremes, limb 1 has two keys at one time, limb 3 ends at the largest time.
    for (int l = 0; l < 4; l++)
      for (int s = 0; s < 8; s++)
        put_key(2'(l), 3'(s), (l == 3 && s == 7) ? 20'hFFFFF :
                (l == 1 && s == 3) ? 20'd1200 : 20'(s * 600),
                (l == 0 && s == 0) ? 16'h8000 : (l == 0 && s == 7) ? 16'h7FFF :
                16'($urandom));
    drain();
    cfg_write(kai_pkg::REG_KEY_COUNT0, 20'd8);
    cfg_write(kai_pkg::REG_KEY_COUNT1, 20'd8);
    cfg_write(kai_pkg::REG_KEY_COUNT2, 20'd1);
    cfg_write(kai_pkg::REG_KEY_COUNT3, 20'd8);
    cfg_write(kai_pkg::REG_PLAY_SPEED, 20'd256);
    tick(16'd1200);                // timer stays clamped at the clip length
    tick(16'd350);
    tick(16'd2000);                // clamped timer lies before the last key of limb 0
    tick(16'hFFFF);
    drain();
    cfg_write(kai_pkg::REG_LOOP_ENABLE, 20'd1);
    cfg_write(kai_pkg::REG_PLAY_SPEED, 20'd4095);
    tick(16'hFFFF);                // wrap with the largest increment
    tick(16'd77);
    drain();
    cfg_write(kai_pkg::REG_CLIP_DURATION, 20'd0);   // zero length while looping
    tick(16'd500);
    drain();
    cfg_write(kai_pkg::REG_PLAY_SPEED, 20'd0);
    cfg_write(kai_pkg::REG_LOOP_ENABLE, 20'd0);
    cfg_write(kai_pkg::REG_CLIP_DURATION, 20'hFFFFF);
    tick(16'hFFFF);                // speed zero holds the timer
    drain();                       // sender holds off until every pose is back

    // Random phases: new settings, some rewritten tracks, then a mixed stream.
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(kai_pkg::REG_CLIP_DURATION, pick_dur());
      cfg_write(kai_pkg::REG_LOOP_ENABLE, 20'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0: cfg_write(kai_pkg::REG_PLAY_SPEED, 20'd0);
        1: cfg_write(kai_pkg::REG_PLAY_SPEED, 20'd4095);
        default: cfg_write(kai_pkg::REG_PLAY_SPEED, 20'($urandom_range(0, 4095)));
      endcase
      cfg_write(kai_pkg::REG_KEY_COUNT0, pick_count());
      cfg_write(kai_pkg::REG_KEY_COUNT1, pick_count());
      cfg_write(kai_pkg::REG_KEY_COUNT2, pick_count());
      cfg_write(kai_pkg::REG_KEY_COUNT3, pick_count());
      send_calm = (ph % 4 == 1);
      recv_calm = (ph % 4 == 2);
      for (int l = 0; l < 4; l++)
        if ($urandom_range(0, 1)) load_track(2'(l), $urandom_range(0, 4) == 0 ? 2 :
                                                    $urandom_range(0, 1));
      for (int n = 0; n < 110; n++)
        if ($urandom_range(0, 9) == 0)
          put_key(2'($urandom), 3'($urandom), 20'($urandom), 16'($urandom));
        else
          tick(pick_delta());
      drain();
    end

    repeat (400) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
